// File: rtl/ckc_pkg.sv
package ckc_pkg;

    localparam int VAL_W       = 17;
    localparam int DIV_W       = 13;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 20;
    localparam int QUOT_W      = VAL_W + RECIP_W - RECIP_SHIFT;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SW_PERIOD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCANS_SEC   = 2'd3;

    localparam logic [7:0] RST_SCAN_PERIOD = 8'd20;
    localparam logic [7:0] RST_LONG_PRESS  = 8'd25;
    localparam logic [7:0] RST_SW_PERIOD   = 8'd10;
    localparam logic [7:0] RST_SCANS_SEC   = 8'd50;

    localparam logic [1:0] VIEW_CLOCK     = 2'd0;
    localparam logic [1:0] VIEW_STOPWATCH = 2'd1;
    localparam logic [1:0] VIEW_SETTING   = 2'd2;

    localparam logic [1:0] FIELD_HOUR = 2'd0;
    localparam logic [1:0] FIELD_MIN  = 2'd1;
    localparam logic [1:0] FIELD_SEC  = 2'd2;

    localparam logic [2:0] KEY_NONE = 3'd0;

    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_UP      = 4'd1;
    localparam logic [3:0] EV_DOWN    = 4'd2;
    localparam logic [3:0] EV_MODE    = 4'd3;
    localparam logic [3:0] EV_CLEAR   = 4'd5;
    localparam logic [3:0] EV_CONFIRM = 4'd6;
    localparam logic [3:0] EV_SETUP   = 4'd7;
    localparam logic [3:0] EV_LONG_OFFSET = 4'd4;

    localparam logic [VAL_W-1:0] DAY_LAST  = 17'd86399;
    localparam logic [15:0]      SW_LAST   = 16'd60001;
    localparam logic [VAL_W-1:0] STEP_HOUR = 17'd3600;
    localparam logic [VAL_W-1:0] STEP_MIN  = 17'd60;
    localparam logic [VAL_W-1:0] STEP_SEC  = 17'd1;

    localparam logic [DIV_W-1:0] DIV_HOUR   = 13'd3600;
    localparam logic [DIV_W-1:0] DIV_MIN    = 13'd60;
    localparam logic [DIV_W-1:0] DIV_SW_MIN = 13'd6000;
    localparam logic [DIV_W-1:0] DIV_SW_SEC = 13'd100;

    localparam logic [RECIP_W-1:0] RECIP_HOUR   = RECIP_W'((1 << RECIP_SHIFT) / 3600);
    localparam logic [RECIP_W-1:0] RECIP_MIN    = RECIP_W'((1 << RECIP_SHIFT) / 60);
    localparam logic [RECIP_W-1:0] RECIP_SW_MIN = RECIP_W'((1 << RECIP_SHIFT) / 6000);
    localparam logic [RECIP_W-1:0] RECIP_SW_SEC = RECIP_W'((1 << RECIP_SHIFT) / 100);

    typedef struct packed {
        logic [1:0] view;
        logic [1:0] field;
        logic       running;
        logic       led;
        logic [3:0] event_code;
        logic       sw;
    } ctrl_t;

    typedef struct packed {
        ctrl_t            ctrl;
        logic [VAL_W-1:0] value;
    } snap_t;

endpackage

// File: rtl/ckc_core.sv
module ckc_core import ckc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 accept,
    input  logic                 advance,
    input  logic [3:0]           keys_down,
    output logic                 snap_valid,
    output snap_t                snap
);

    logic [7:0]       scan_period_reg, long_press_reg, sw_period_reg, scans_sec_reg;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       scan_cnt_reg, scan_cnt_next;
    logic [7:0]       centi_reg, centi_next;
    logic [2:0]       prev_key_reg, prev_key_next;
    logic [2:0]       cur_key_reg, cur_key_next;
    logic [15:0]      held_reg, held_next;
    logic [VAL_W-1:0] day_reg, day_next;
    logic [VAL_W-1:0] set_reg, set_next;
    logic [15:0]      sw_reg, sw_next;
    logic [1:0]       view_reg, view_next;
    logic [1:0]       field_reg, field_next;
    logic             running_reg, running_next;
    logic             led_reg, led_next;
    logic             snap_valid_reg;
    snap_t            snap_reg, snap_next;

    logic [7:0]       tick_inc, centi_inc, scan_inc;
    logic             scan_hit, centi_hit, sec_hit;
    logic [2:0]       key_sel;
    logic [3:0]       ev;
    logic [VAL_W-1:0] step;
    logic [VAL_W:0]   step_sum;

    always_comb
    begin
        tick_inc  = tick_reg + 8'd1;
        centi_inc = centi_reg + 8'd1;
        scan_hit  = (tick_inc >= scan_period_reg);
        tick_next = scan_hit ? 8'd0 : tick_inc;
        scan_inc  = scan_hit ? scan_cnt_reg + 8'd1 : scan_cnt_reg;

        if (keys_down[3])
            key_sel = 3'd4;
        else if (keys_down[2])
            key_sel = 3'd3;
        else if (keys_down[1])
            key_sel = 3'd2;
        else if (keys_down[0])
            key_sel = 3'd1;
        else
            key_sel = KEY_NONE;

        prev_key_next = prev_key_reg;
        cur_key_next  = cur_key_reg;
        held_next     = held_reg;
        ev            = EV_NONE;
        if (scan_hit)
        begin
            prev_key_next = cur_key_reg;
            cur_key_next  = key_sel;
            if (key_sel != KEY_NONE)
            begin
                if (held_reg != 16'hFFFF)
                    held_next = held_reg + 16'd1;
            end
            else if (cur_key_reg != KEY_NONE)
            begin
                ev = (held_reg > {8'd0, long_press_reg}) ?
                     {1'b0, cur_key_reg} + EV_LONG_OFFSET : {1'b0, cur_key_reg};
                held_next = 16'd0;
            end
        end

        centi_hit  = (centi_inc >= sw_period_reg);
        centi_next = centi_hit ? 8'd0 : centi_inc;
        sw_next    = sw_reg;
        if (centi_hit && running_reg)
            sw_next = (sw_reg < SW_LAST) ? sw_reg + 16'd1 : 16'd0;

        sec_hit       = (scan_inc >= scans_sec_reg);
        scan_cnt_next = sec_hit ? 8'd0 : scan_inc;
        day_next      = day_reg;
        if (sec_hit)
            day_next = (day_reg >= DAY_LAST) ? '0 : day_reg + 17'd1;

        case (field_reg)
            FIELD_HOUR: step = STEP_HOUR;
            FIELD_MIN:  step = STEP_MIN;
            FIELD_SEC:  step = STEP_SEC;
            default:    step = '0;
        endcase
        step_sum = {1'b0, set_reg} + {1'b0, step};

        set_next     = set_reg;
        view_next    = view_reg;
        field_next   = field_reg;
        running_next = running_reg;
        led_next     = led_reg;
        case (ev)
            EV_UP:
            begin
                if (view_reg == VIEW_STOPWATCH)
                    running_next = ~running_reg;
                if (view_reg == VIEW_SETTING && step_sum <= {1'b0, DAY_LAST})
                    set_next = step_sum[VAL_W-1:0];
            end
            EV_DOWN:
            begin
                if (view_reg == VIEW_SETTING && set_reg >= step)
                    set_next = set_reg - step;
            end
            EV_MODE:
            begin
                if (view_reg == VIEW_CLOCK)
                    view_next = VIEW_STOPWATCH;
                else if (view_reg == VIEW_SETTING)
                    field_next = (field_reg >= FIELD_SEC) ? FIELD_HOUR : field_reg + 2'd1;
                else
                    view_next = VIEW_CLOCK;
            end
            EV_CLEAR:
            begin
                if (view_reg == VIEW_STOPWATCH)
                    sw_next = 16'd0;
            end
            EV_CONFIRM:
            begin
                if (view_reg == VIEW_SETTING)
                begin
                    day_next = set_reg;
                    led_next = ~led_reg;
                end
            end
            EV_SETUP:
            begin
                if (view_reg != VIEW_SETTING)
                begin
                    set_next  = '0;
                    view_next = VIEW_SETTING;
                end
                else
                begin
                    view_next = VIEW_CLOCK;
                end
            end
            default:
            begin
            end
        endcase

        snap_next.ctrl.view       = view_next;
        snap_next.ctrl.field      = field_next;
        snap_next.ctrl.running    = running_next;
        snap_next.ctrl.led        = led_next;
        snap_next.ctrl.event_code = ev;
        snap_next.ctrl.sw         = (view_next == VIEW_STOPWATCH);
        if (view_next == VIEW_STOPWATCH)
            snap_next.value = {1'b0, sw_next};
        else if (view_next == VIEW_SETTING)
            snap_next.value = set_next;
        else
            snap_next.value = day_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg <= RST_SCAN_PERIOD;
            long_press_reg  <= RST_LONG_PRESS;
            sw_period_reg   <= RST_SW_PERIOD;
            scans_sec_reg   <= RST_SCANS_SEC;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCAN_PERIOD: scan_period_reg <= cfg_data;
                CFG_LONG_PRESS:  long_press_reg  <= cfg_data;
                CFG_SW_PERIOD:   sw_period_reg   <= cfg_data;
                CFG_SCANS_SEC:   scans_sec_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            scan_cnt_reg <= '0;
            centi_reg    <= '0;
            prev_key_reg <= KEY_NONE;
            cur_key_reg  <= KEY_NONE;
            held_reg     <= '0;
            day_reg      <= '0;
            set_reg      <= '0;
            sw_reg       <= '0;
            view_reg     <= VIEW_CLOCK;
            field_reg    <= FIELD_HOUR;
            running_reg  <= 1'b0;
            led_reg      <= 1'b0;
        end
        else if (accept)
        begin
            tick_reg     <= tick_next;
            scan_cnt_reg <= scan_cnt_next;
            centi_reg    <= centi_next;
            prev_key_reg <= prev_key_next;
            cur_key_reg  <= cur_key_next;
            held_reg     <= held_next;
            day_reg      <= day_next;
            set_reg      <= set_next;
            sw_reg       <= sw_next;
            view_reg     <= view_next;
            field_reg    <= field_next;
            running_reg  <= running_next;
            led_reg      <= led_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (advance)
            snap_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// File: rtl/ckc_divmod.sv
module ckc_divmod import ckc_pkg::*;
(
    input  logic               clk,
    input  logic               advance,
    input  logic [VAL_W-1:0]   value,
    input  logic [RECIP_W-1:0] recip,
    input  logic [DIV_W-1:0]   divisor,
    output logic [QUOT_W-1:0]  quot,
    output logic [DIV_W-1:0]   rem
);

    logic [VAL_W-1:0]         val_reg;
    logic [DIV_W-1:0]         div_reg;
    logic [QUOT_W-1:0]        qest_reg, qest_next;
    logic [QUOT_W-1:0]        quot_reg, quot_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [VAL_W+RECIP_W-1:0] prod;
    logic [QUOT_W+DIV_W-1:0]  back;
    logic [VAL_W-1:0]         diff;
    logic [VAL_W-1:0]         diff_fix;

    // estimate is exact or one low
    always_comb
    begin
        prod      = {{RECIP_W{1'b0}}, value} * {{VAL_W{1'b0}}, recip};
        qest_next = prod[RECIP_SHIFT +: QUOT_W];
    end

    always_comb
    begin
        back     = {{DIV_W{1'b0}}, qest_reg} * {{QUOT_W{1'b0}}, div_reg};
        diff     = val_reg - back[VAL_W-1:0];
        diff_fix = diff - {{(VAL_W-DIV_W){1'b0}}, div_reg};
        if (diff >= {{(VAL_W-DIV_W){1'b0}}, div_reg})
        begin
            quot_next = qest_reg + {{(QUOT_W-1){1'b0}}, 1'b1};
            rem_next  = diff_fix[DIV_W-1:0];
        end
        else
        begin
            quot_next = qest_reg;
            rem_next  = diff[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            val_reg  <= value;
            div_reg  <= divisor;
            qest_reg <= qest_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/clock_stopwatch_key_controller_top.sv
// Clock and stopwatch with key controller.
// Input channel (in_valid / in_ready / keys_down): one request per 1 ms tick,
// carrying the four key levels. Key events, clock, stopwatch and menu state
// are all updated when the request is accepted.
// Output channel (out_valid / out_ready): one result per request, holding the
// view, the selected set field, the three displayed numbers, the stopwatch
// run flag, the confirm LED and the key event decoded on that tick.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): write
// while idle; cfg_ready is always high; indexes 0..3 select scan period, long
// press threshold, stopwatch period and scans per second.
// Pipeline: an accepted request goes through the state update, then two
// divide-by-constant units of two stages each (hours, then minutes/seconds;
// in stopwatch view minutes, then seconds/hundredths).
// Throughput: one request per cycle while out_ready is high.
// Receiver stall: while a result waits with out_ready low, the whole pipeline
// holds and in_ready is low.
// Reset: configuration back to 20/25/10/50, clock 00:00:00, clock view,
// stopwatch stopped and cleared, no result pending.
module clock_stopwatch_key_controller_top import ckc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           keys_down,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           view,
    output logic [1:0]           edit_field,
    output logic [6:0]           shown_high,
    output logic [5:0]           shown_mid,
    output logic [6:0]           shown_low,
    output logic                 stopwatch_running,
    output logic                 confirm_led,
    output logic [3:0]           key_event
);

    logic              advance;
    logic              accept;
    logic              s1_valid;
    snap_t             s1;
    logic              s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    ctrl_t             s2_ctrl_reg, s3_ctrl_reg, s4_ctrl_reg, out_ctrl_reg;
    logic [QUOT_W-1:0] s4_hi_reg, out_hi_reg;
    logic [RECIP_W-1:0] recip_a, recip_b;
    logic [DIV_W-1:0]  div_a, div_b;
    logic [QUOT_W-1:0] quot_a, quot_b;
    logic [DIV_W-1:0]  rem_a, rem_b;

    assign advance   = !out_valid_reg || out_ready;
    assign accept    = in_valid && advance;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    ckc_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .advance    (advance),
        .keys_down  (keys_down),
        .snap_valid (s1_valid),
        .snap       (s1)
    );

    assign recip_a = s1.ctrl.sw ? RECIP_SW_MIN : RECIP_HOUR;
    assign div_a   = s1.ctrl.sw ? DIV_SW_MIN : DIV_HOUR;
    assign recip_b = s3_ctrl_reg.sw ? RECIP_SW_SEC : RECIP_MIN;
    assign div_b   = s3_ctrl_reg.sw ? DIV_SW_SEC : DIV_MIN;

    ckc_divmod u_div_hi
    (
        .clk     (clk),
        .advance (advance),
        .value   (s1.value),
        .recip   (recip_a),
        .divisor (div_a),
        .quot    (quot_a),
        .rem     (rem_a)
    );

    ckc_divmod u_div_lo
    (
        .clk     (clk),
        .advance (advance),
        .value   ({{(VAL_W-DIV_W){1'b0}}, rem_a}),
        .recip   (recip_b),
        .divisor (div_b),
        .quot    (quot_b),
        .rem     (rem_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s1_valid;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_ctrl_reg  <= s1.ctrl;
            s3_ctrl_reg  <= s2_ctrl_reg;
            s4_ctrl_reg  <= s3_ctrl_reg;
            out_ctrl_reg <= s4_ctrl_reg;
            s4_hi_reg    <= quot_a;
            out_hi_reg   <= s4_hi_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign view              = out_ctrl_reg.view;
    assign edit_field        = out_ctrl_reg.field;
    assign shown_high        = out_hi_reg[6:0];
    assign shown_mid         = quot_b[5:0];
    assign shown_low         = rem_b[6:0];
    assign stopwatch_running = out_ctrl_reg.running;
    assign confirm_led       = out_ctrl_reg.led;
    assign key_event         = out_ctrl_reg.event_code;

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid |-> s1.value <= DAY_LAST)
        else $error("displayed value out of range");

    a_clock_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && view != VIEW_STOPWATCH |->
            shown_high <= 7'd23 && shown_mid <= 6'd59 && shown_low <= 7'd59)
        else $error("clock digits out of range");

    a_sw_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && view == VIEW_STOPWATCH |->
            shown_high <= 7'd10 && shown_mid <= 6'd59 && shown_low <= 7'd99)
        else $error("stopwatch digits out of range");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_event != EV_NONE |-> key_event <= 4'd8)
        else $error("bad key event");

endmodule
